>>> src/dfe_pkg.sv
// ----------------------------------------------------------------------------
// dfe_pkg
// Shared types and constants of the display frame encoder.
// ----------------------------------------------------------------------------
package dfe_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [BYTE_W-1:0] MARK_WIDTH  = 8'hd0;
	localparam logic [BYTE_W-1:0] MARK_HEIGHT = 8'hd1;
	localparam logic [BYTE_W-1:0] ESC_BYTE    = 8'hfe;
	localparam logic [BYTE_W-1:0] ESC_FE      = 8'h00;
	localparam logic [BYTE_W-1:0] ESC_FF      = 8'h01;
	localparam logic [BYTE_W-1:0] RAW_FF      = 8'hff;
	localparam logic [BYTE_W-1:0] CLOSE_BYTE  = 8'h00;

	localparam logic [CFG_IDX_W-1:0] REG_START   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STOP    = 3'd5;

	typedef struct packed {
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] display_address;
		logic [BYTE_W-1:0] mode_byte;
		logic [BYTE_W-1:0] display_width;
		logic [BYTE_W-1:0] display_height;
		logic [BYTE_W-1:0] stop_byte;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              run_last;
		logic              frame_end;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_START,
		ST_ADDR,
		ST_MODE,
		ST_WMARK,
		ST_WIDTH,
		ST_HMARK,
		ST_HEIGHT,
		ST_PAYLOAD,
		ST_CSUM,
		ST_CSUM_ESC,
		ST_STOP,
		ST_CLOSE
	} step_t;

endpackage

>>> src/dfe_cfg.sv
// ----------------------------------------------------------------------------
// dfe_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dfe_cfg
	import dfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte      <= 8'hff;
			cfg_q.display_address <= 8'h00;
			cfg_q.mode_byte       <= 8'ha2;
			cfg_q.display_width   <= 8'd28;
			cfg_q.display_height  <= 8'd16;
			cfg_q.stop_byte       <= 8'hff;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_START:   cfg_q.start_byte      <= cfg_wdata;
				REG_ADDRESS: cfg_q.display_address <= cfg_wdata;
				REG_MODE:    cfg_q.mode_byte       <= cfg_wdata;
				REG_WIDTH:   cfg_q.display_width   <= cfg_wdata;
				REG_HEIGHT:  cfg_q.display_height  <= cfg_wdata;
				REG_STOP:    cfg_q.stop_byte       <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/dfe_seq.sv
// ----------------------------------------------------------------------------
// dfe_seq
// Holds one input item and steps through its header, payload and trailer
// bytes as needed, one per cycle while taken, keeping the frame checksum.
// ----------------------------------------------------------------------------
module dfe_seq
	import dfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_payload,
	input  logic              in_last,
	output logic              item_valid,
	input  logic              item_ready,
	output out_item_t         item
);

	logic              hold_valid_q;
	logic [BYTE_W-1:0] payload_q;
	logic              last_q;
	step_t             step_q;
	step_t             step_nx;
	logic              in_frame_q;
	logic              in_frame_d;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] cur_byte;
	logic              summed;
	logic              final_step;
	logic              emit;
	logic              accept;
	logic              sum_esc;

	assign sum_esc = (sum_q == ESC_BYTE) || (sum_q == RAW_FF);

	always_comb begin
		cur_byte   = payload_q;
		summed     = 1'b0;
		final_step = 1'b0;
		step_nx    = step_q;
		case (step_q)
			ST_START: begin
				cur_byte = cfg.start_byte;
				step_nx  = ST_ADDR;
			end
			ST_ADDR: begin
				cur_byte = cfg.display_address;
				summed   = 1'b1;
				step_nx  = ST_MODE;
			end
			ST_MODE: begin
				cur_byte = cfg.mode_byte;
				summed   = 1'b1;
				step_nx  = ST_WMARK;
			end
			ST_WMARK: begin
				cur_byte = MARK_WIDTH;
				summed   = 1'b1;
				step_nx  = ST_WIDTH;
			end
			ST_WIDTH: begin
				cur_byte = cfg.display_width;
				summed   = 1'b1;
				step_nx  = ST_HMARK;
			end
			ST_HMARK: begin
				cur_byte = MARK_HEIGHT;
				summed   = 1'b1;
				step_nx  = ST_HEIGHT;
			end
			ST_HEIGHT: begin
				cur_byte = cfg.display_height;
				summed   = 1'b1;
				step_nx  = ST_PAYLOAD;
			end
			ST_PAYLOAD: begin
				cur_byte   = payload_q;
				summed     = 1'b1;
				final_step = !last_q;
				step_nx    = ST_CSUM;
			end
			ST_CSUM: begin
				cur_byte = sum_esc ? ESC_BYTE : sum_q;
				step_nx  = sum_esc ? ST_CSUM_ESC : ST_STOP;
			end
			ST_CSUM_ESC: begin
				cur_byte = (sum_q == RAW_FF) ? ESC_FF : ESC_FE;
				step_nx  = ST_STOP;
			end
			ST_STOP: begin
				cur_byte = cfg.stop_byte;
				step_nx  = ST_CLOSE;
			end
			ST_CLOSE: begin
				cur_byte   = CLOSE_BYTE;
				final_step = 1'b1;
				step_nx    = ST_CLOSE;
			end
			default: begin
				cur_byte = payload_q;
			end
		endcase
	end

	assign emit     = hold_valid_q && item_ready;
	assign in_ready = !hold_valid_q || (emit && final_step);
	assign accept   = in_valid && in_ready;

	always_comb begin
		in_frame_d = in_frame_q;
		if (emit && (step_q == ST_START)) begin
			in_frame_d = 1'b1;
		end else if (emit && (step_q == ST_CLOSE)) begin
			in_frame_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			step_q       <= ST_START;
			in_frame_q   <= 1'b0;
			sum_q        <= '0;
		end else begin
			in_frame_q <= in_frame_d;
			if (accept) begin
				hold_valid_q <= 1'b1;
				step_q       <= in_frame_d ? ST_PAYLOAD : ST_START;
			end else if (emit && final_step) begin
				hold_valid_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_nx;
			end
			if (emit && (step_q == ST_START)) begin
				sum_q <= '0;
			end else if (emit && summed) begin
				sum_q <= sum_q + cur_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			payload_q <= in_payload;
			last_q    <= in_last;
		end
	end

	assign item_valid     = hold_valid_q;
	assign item.out_byte  = cur_byte;
	assign item.run_last  = final_step;
	assign item.frame_end = (step_q == ST_CLOSE);

	a_close_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (step_q == ST_CLOSE)) |-> in_frame_q)
		else $error("frame closed while no frame open");

	a_start_not_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_valid_q && (step_q == ST_START)) |-> !in_frame_q)
		else $error("header started inside an open frame");

	a_esc_only_when_needed: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_valid_q && (step_q == ST_CSUM_ESC)) |-> sum_esc)
		else $error("checksum escape without an escaped value");

	a_accept_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> hold_valid_q)
		else $error("accepted item not held");

endmodule

>>> src/dfe_out.sv
// ----------------------------------------------------------------------------
// dfe_out
// Output register between the byte sequencer and the output stream.
// ----------------------------------------------------------------------------
module dfe_out
	import dfe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  out_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic      valid_q;
	out_item_t item_q;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= in_item;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

>>> src/display_frame_encoder.sv
// ----------------------------------------------------------------------------
// display_frame_encoder
// Wraps a payload byte stream into display bus frames with header, escaped
// checksum and trailer.
// ----------------------------------------------------------------------------
// Every input item emits bytes from a single sequencer, one output byte per
// cycle unless the output register stalls: the first item of a frame adds
// the 7 header bytes, and an item marked last adds the checksum (1 or 2
// bytes), the stop byte and the closing 0x00. The next item is taken in the
// same cycle as the previous item's last byte leaves the sequencer; an
// output register decouples the stream sink. Configuration should be
// written while no frame item is in flight.
module display_frame_encoder
	import dfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] payload_byte
	input  logic                 s_tlast,   // frame_last
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
	output logic                 m_tlast,   // run_last
	output logic                 m_tuser    // [0] frame_end
);

	cfg_t      cfg;
	logic      seq_valid;
	logic      seq_ready;
	out_item_t seq_item;
	out_item_t out_item;

	dfe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dfe_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_payload (s_tdata),
		.in_last    (s_tlast),
		.item_valid (seq_valid),
		.item_ready (seq_ready),
		.item       (seq_item)
	);

	dfe_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seq_valid),
		.in_ready  (seq_ready),
		.in_item   (seq_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	assign m_tdata = out_item.out_byte;
	assign m_tlast = out_item.run_last;
	assign m_tuser = out_item.frame_end;

endmodule

>>> sim/display_frame_encoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_frame_encoder_checker
// Watches the config port and both streams of the display frame encoder,
// predicts every framed output byte and compares it with what comes out.
// ----------------------------------------------------------------------------
module display_frame_encoder_checker
	import dfe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] payload_byte
	input  logic                 s_tlast,   // frame_last
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
	input  logic                 m_tlast,   // run_last
	input  logic                 m_tuser,   // [0] frame_end
	output int                   errors,
	output int                   pending
);

	localparam cfg_t REG_DEFAULTS = '{8'hff, 8'h00, 8'ha2, 8'd28, 8'd16, 8'hff};

	cfg_t              regs;
	logic              frame_open;
	logic [BYTE_W-1:0] frame_sum;
	out_item_t         frame_bytes_q[$];
	out_item_t         want;
	int                err_count;

	task automatic emit_byte(input logic [BYTE_W-1:0] b, input logic summed,
			input logic run_end, input logic closing);
		out_item_t it;
		it.out_byte  = b;
		it.run_last  = run_end;
		it.frame_end = closing;
		frame_bytes_q.push_back(it);
		if (summed)
			frame_sum = frame_sum + b;
	endtask

	task automatic encode_payload(input logic [BYTE_W-1:0] payload, input logic last);
		logic [BYTE_W-1:0] csum;
		if (!frame_open) begin
			frame_sum = '0;
			emit_byte(regs.start_byte, 1'b0, 1'b0, 1'b0);
			emit_byte(regs.display_address, 1'b1, 1'b0, 1'b0);
			emit_byte(regs.mode_byte, 1'b1, 1'b0, 1'b0);
			emit_byte(MARK_WIDTH, 1'b1, 1'b0, 1'b0);
			emit_byte(regs.display_width, 1'b1, 1'b0, 1'b0);
			emit_byte(MARK_HEIGHT, 1'b1, 1'b0, 1'b0);
			emit_byte(regs.display_height, 1'b1, 1'b0, 1'b0);
			frame_open = 1'b1;
		end
		emit_byte(payload, 1'b1, !last, 1'b0);
		if (last) begin
			csum = frame_sum;
			if (csum == ESC_BYTE) begin
				emit_byte(ESC_BYTE, 1'b0, 1'b0, 1'b0);
				emit_byte(ESC_FE, 1'b0, 1'b0, 1'b0);
			end else if (csum == RAW_FF) begin
				emit_byte(ESC_BYTE, 1'b0, 1'b0, 1'b0);
				emit_byte(ESC_FF, 1'b0, 1'b0, 1'b0);
			end else begin
				emit_byte(csum, 1'b0, 1'b0, 1'b0);
			end
			emit_byte(regs.stop_byte, 1'b0, 1'b0, 1'b0);
			emit_byte(CLOSE_BYTE, 1'b0, 1'b1, 1'b1);
			frame_open = 1'b0;
			frame_sum  = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs       = REG_DEFAULTS;
			frame_open = 1'b0;
			frame_sum  = '0;
			err_count  = 0;
			frame_bytes_q.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_START:   regs.start_byte      = cfg_wdata;
					REG_ADDRESS: regs.display_address = cfg_wdata;
					REG_MODE:    regs.mode_byte       = cfg_wdata;
					REG_WIDTH:   regs.display_width   = cfg_wdata;
					REG_HEIGHT:  regs.display_height  = cfg_wdata;
					REG_STOP:    regs.stop_byte       = cfg_wdata;
					default: ;
				endcase
			end
			// outputs first: a byte seen at this edge cannot stem from an item taken now
			if (m_tvalid && m_tready) begin
				if (frame_bytes_q.size() == 0) begin
					err_count++;
					$display("%0t: unexpected byte, expected none, actual %h/%b/%b",
						$time, m_tdata, m_tlast, m_tuser);
				end else begin
					want = frame_bytes_q.pop_front();
					if (m_tdata !== want.out_byte || m_tlast !== want.run_last ||
							m_tuser !== want.frame_end) begin
						err_count++;
						$display("%0t: byte mismatch, expected %h/%b/%b, actual %h/%b/%b",
							$time, want.out_byte, want.run_last, want.frame_end,
							m_tdata, m_tlast, m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready)
				encode_payload(s_tdata, s_tlast);
			errors  <= err_count;
			pending <= frame_bytes_q.size();
		end
	end

endmodule

>>> sim/display_frame_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_frame_encoder_tb
// Drives payload frames and register settings into the display frame encoder
// with random stalls on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module display_frame_encoder_tb;
	import dfe_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 20;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam cfg_t REG_DEFAULTS = '{8'hff, 8'h00, 8'ha2, 8'd28, 8'd16, 8'hff};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [BYTE_W-1:0]    m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;

	int errors;
	int pending;
	int cycles    = 0;
	int src_calm  = 0;
	int sink_calm = 0;

	// stimulus-side view, only used to steer checksums
	cfg_t              cur;
	logic              frame_open;
	logic [BYTE_W-1:0] frame_acc;

	display_frame_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	display_frame_encoder_checker u_frame_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// stretches of zero gaps now and then
	function automatic int next_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 5) == 0)
			calm = $urandom_range(8, 24);
		return $urandom_range(0, 7);
	endfunction

	function automatic logic [BYTE_W-1:0] header_sum(input cfg_t c);
		return c.display_address + c.mode_byte + MARK_WIDTH + c.display_width +
			MARK_HEIGHT + c.display_height;
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.start_byte      = BYTE_W'($urandom_range(0, 255));
		c.display_address = BYTE_W'($urandom_range(0, 255));
		c.mode_byte       = BYTE_W'($urandom_range(0, 255));
		c.display_width   = BYTE_W'($urandom_range(0, 255));
		c.display_height  = BYTE_W'($urandom_range(0, 255));
		c.stop_byte       = BYTE_W'($urandom_range(0, 255));
		return c;
	endfunction

	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		gap = next_gap(sink_calm);
		forever begin
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			gap = next_gap(sink_calm);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		int gap;
		gap = next_gap(src_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (!frame_open)
			frame_acc = header_sum(cur);
		frame_acc  = frame_acc + b;
		frame_open = !last;
	endtask

	// closes the frame so that its checksum lands on target
	task automatic close_to(input logic [BYTE_W-1:0] target);
		logic [BYTE_W-1:0] base;
		base = frame_open ? frame_acc : header_sum(cur);
		send_byte(target - base, 1'b1);
	endtask

	task automatic poke(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_regs(input cfg_t c);
		poke(REG_START, c.start_byte);
		poke(REG_ADDRESS, c.display_address);
		poke(REG_MODE, c.mode_byte);
		poke(REG_WIDTH, c.display_width);
		poke(REG_HEIGHT, c.display_height);
		poke(REG_STOP, c.stop_byte);
		cur = c;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int sent;
		int len;
		cfg_t c;
		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = REG_START;
		cfg_wdata  = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		cur        = REG_DEFAULTS;
		frame_open = 1'b0;
		frame_acc  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single-byte and multi-byte frames, both escapes
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'haa, 1'b1);
		close_to(ESC_BYTE);
		close_to(RAW_FF);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		close_to(ESC_BYTE);
		send_byte(8'h80, 1'b0);
		close_to(RAW_FF);

		// register writes while a frame is open
		send_byte(8'h01, 1'b0);
		settle();
		poke(REG_STOP, 8'h5a);
		poke(REG_ADDRESS, 8'h3c);
		cur.stop_byte       = 8'h5a;
		cur.display_address = 8'h3c;
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b1);
		settle();

		// writes to unused indexes are dropped
		poke(REG_SPARE_LO, 8'h00);
		poke(REG_SPARE_HI, 8'hff);
		send_byte(8'h7e, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph == 0)
				c = '0;
			else if (ph == 1)
				c = '1;
			else
				c = random_cfg();
			load_regs(c);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
				for (int k = 1; k < len; k++)
					send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
				case ($urandom_range(0, 3))
					0:       close_to(ESC_BYTE);
					1:       close_to(RAW_FF);
					default: send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
				endcase
				sent += len;
			end
		end
		settle();

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
